### hw/rtl/weighted_fair_task_scheduler_core_assert.svh
// Assertion macros for the weighted fair task scheduler core.
`ifndef WEIGHTED_FAIR_TASK_SCHEDULER_CORE_ASSERT_SVH
`define WEIGHTED_FAIR_TASK_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define WFTS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define WFTS_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define WFTS_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define WFTS_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

### hw/rtl/wfts_pkg.sv
// Package with types, codes and the weight table of the scheduler.
package wfts_pkg;
    localparam int MAX_TASKS_DEF = 32;
    localparam int PRIORITY_LEVELS = 40;

    localparam logic [2:0] CMD_TICK = 3'd0;
    localparam logic [2:0] CMD_ADD = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_SETPRIO = 3'd3;
    localparam logic [2:0] CMD_YIELD = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_PRIO = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SLOT = 2'd3;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_MINSW = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_RDSLOT, S_DECIDE, S_CHARGE, S_MUL, S_WRRUN, S_DIV,
        S_SCAN, S_SCANEND, S_FINAL
    } state_t;

    // Request from the sequencer to the divider, and its reply.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [8:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    function automatic logic [14:0] weight_of(input logic [5:0] p);
        logic [14:0] w;
        case (p)
            6'd0: w = 15'd10;     6'd1: w = 15'd12;     6'd2: w = 15'd15;
            6'd3: w = 15'd18;     6'd4: w = 15'd22;     6'd5: w = 15'd27;
            6'd6: w = 15'd33;     6'd7: w = 15'd40;     6'd8: w = 15'd49;
            6'd9: w = 15'd60;     6'd10: w = 15'd73;    6'd11: w = 15'd89;
            6'd12: w = 15'd109;   6'd13: w = 15'd133;   6'd14: w = 15'd162;
            6'd15: w = 15'd197;   6'd16: w = 15'd241;   6'd17: w = 15'd294;
            6'd18: w = 15'd358;   6'd19: w = 15'd437;   6'd20: w = 15'd534;
            6'd21: w = 15'd651;   6'd22: w = 15'd794;   6'd23: w = 15'd969;
            6'd24: w = 15'd1182;  6'd25: w = 15'd1442;  6'd26: w = 15'd1759;
            6'd27: w = 15'd2146;  6'd28: w = 15'd2619;  6'd29: w = 15'd3195;
            6'd30: w = 15'd3898;  6'd31: w = 15'd4755;  6'd32: w = 15'd5801;
            6'd33: w = 15'd7077;  6'd34: w = 15'd8634;  6'd35: w = 15'd10534;
            6'd36: w = 15'd12852; 6'd37: w = 15'd15679; 6'd38: w = 15'd19128;
            default: w = 15'd23336;
        endcase
        return w;
    endfunction
endpackage

### hw/rtl/wfts_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module wfts_divider
    import wfts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [31:0] quo_reg, quo_next;
    logic [8:0]  rem_reg, rem_next;
    logic [8:0]  dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [9:0]  trial;

    // One shift and trial subtract a cycle.
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[31]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[9])
            begin
                rem_next = trial[8:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[7:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

### hw/rtl/weighted_fair_task_scheduler_core.sv
// Top level: command sequencer, slot memory, table scan and result port.
// Path: an empty tick or yield and a tick without a switch go straight to the final state;
// other rejected or plain commands read the slot and decide; a switch charges the runtime,
// writes it back and scans the table; removal of the running task first waits for the division.
// One command at a time; a new one is taken in the done cycle; the receiver cannot stall.
// Reset (rst_n low, asynchronous) clears all valid bits and control state at once.
module weighted_fair_task_scheduler_core
    import wfts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [4:0]  task_slot,
    input  logic [5:0]  new_priority,
    input  logic        fresh_task,
    input  logic [31:0] elapsed_ns,
    output logic        done,
    output logic [4:0]  running_slot,
    output logic        running_valid,
    output logic [31:0] wait_ns,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
`include "weighted_fair_task_scheduler_core_assert.svh"
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    // Slot memory entry: priority, runtime and order stamp.
    typedef struct packed {
        logic [5:0]  prio;
        logic [63:0] vr;
        logic [15:0] stamp;
    } entry_t;

    entry_t mem [MAX_TASKS];
    entry_t rd_data;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [IW-1:0] run_reg, run_next;
    logic run_p_reg, run_p_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [63:0] minrt_reg, minrt_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] swi_reg, swi_next;
    logic [15:0] stc_reg, stc_next;
    logic [31:0] period_reg, minsw_reg;
    logic [2:0]  cmd_reg, cmd_next;
    logic [4:0]  slot_reg, slot_next;
    logic [5:0]  prio_reg, prio_next;
    logic        fresh_reg, fresh_next;
    logic [1:0]  st_reg, st_next;
    logic        need_pick_reg, need_pick_next;
    logic [31:0] mula_reg, mula_next;
    logic [14:0] mulb_reg, mulb_next;
    logic        half_reg, half_next;
    logic [46:0] prod_reg;
    entry_t      cur_reg, cur_next;
    logic [IW:0] scan_reg, scan_next;
    logic        found_reg, found_next;
    logic [IW-1:0] best_reg, best_next;
    logic [63:0] bkey_reg, bkey_next;
    logic [15:0] bage_reg, bage_next;
    logic [63:0] bvr_reg, bvr_next;
    logic [15:0] oldest_reg, oldest_next;
    logic        done_reg, done_next;
    div_req_t    dreq;
    div_rsp_t    drsp;

    wfts_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic slot_ok;
    logic [IW-1:0] slot_idx;
    logic [IW:0] scan_prev;
    logic [63:0] key;
    logic [15:0] age;
    logic [32:0] sum;
    logic [63:0] lim, delta;
    logic [46:0] prodv;
    logic [31:0] q;

    assign slot_ok = {27'd0, slot_reg} < 32'(MAX_TASKS);
    assign slot_idx = IW'(slot_reg);
    assign scan_prev = scan_reg - 1'b1;
    assign key = rd_data.vr - minrt_reg;
    assign age = stc_reg - rd_data.stamp;
    assign sum = {1'b0, acc_reg} + {1'b0, elapsed_ns};
    assign lim = {32'd0, period_reg} * {49'd0, weight_of(prio_reg)};
    assign delta = cur_reg.vr - minrt_reg;
    assign q = drsp.quotient;

    // Registered multiplier.
    always_ff @(posedge clk)
        prod_reg <= {15'd0, mula_reg} * {32'd0, mulb_reg};
    assign prodv = half_reg ? {1'b0, prod_reg[46:1]} : prod_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        run_next = run_reg;
        run_p_next = run_p_reg;
        cnt_next = cnt_reg;
        minrt_next = minrt_reg;
        acc_next = acc_reg;
        swi_next = swi_reg;
        stc_next = stc_reg;
        cmd_next = cmd_reg;
        slot_next = slot_reg;
        prio_next = prio_reg;
        fresh_next = fresh_reg;
        st_next = st_reg;
        need_pick_next = need_pick_reg;
        mula_next = mula_reg;
        mulb_next = mulb_reg;
        half_next = half_reg;
        cur_next = cur_reg;
        scan_next = scan_reg;
        found_next = found_reg;
        best_next = best_reg;
        bkey_next = bkey_reg;
        bage_next = bage_reg;
        bvr_next = bvr_reg;
        oldest_next = oldest_reg;
        done_next = 1'b0;
        rd_addr = slot_idx;
        wr_en = 1'b0;
        wr_addr = slot_idx;
        wr_data = cur_reg;
        dreq.start = 1'b0;
        dreq.dividend = period_reg;
        dreq.divisor = 9'(cnt_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    slot_next = task_slot;
                    prio_next = new_priority;
                    fresh_next = fresh_task;
                    st_next = ST_OK;
                    need_pick_next = 1'b0;
                    state_next = S_RDSLOT;
                    if (cmd == CMD_TICK)
                    begin
                        if (cnt_reg == '0 || !run_p_reg)
                        begin
                            st_next = ST_EMPTY;
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            acc_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            if (acc_next >= swi_reg)
                            begin
                                mula_next = acc_next;
                                half_next = 1'b0;
                                acc_next = '0;
                            end
                            else
                                state_next = S_FINAL;
                        end
                    end
                    else if (cmd == CMD_YIELD)
                    begin
                        if (cnt_reg == '0 || !run_p_reg)
                        begin
                            st_next = ST_EMPTY;
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            mula_next = swi_reg;
                            half_next = 1'b1;
                        end
                    end
                end
            end
            S_RDSLOT:
            begin
                // Memory read issued here for the slot or the running task.
                if (cmd_reg == CMD_TICK || cmd_reg == CMD_YIELD)
                    rd_addr = run_reg;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cur_next = rd_data;
                state_next = S_FINAL;
                case (cmd_reg)
                    CMD_TICK, CMD_YIELD:
                    begin
                        mulb_next = weight_of(rd_data.prio);
                        need_pick_next = 1'b1;
                        state_next = S_CHARGE;
                    end
                    CMD_ADD:
                    begin
                        if (prio_reg >= 6'(PRIORITY_LEVELS))
                            st_next = ST_PRIO;
                        else if (!slot_ok || valid_reg[slot_idx])
                            st_next = ST_SLOT;
                        else
                        begin
                            cur_next.prio = prio_reg;
                            if (fresh_reg)
                                cur_next.vr = minrt_reg;
                            state_next = S_CHARGE;
                            scan_next = '0;
                            oldest_next = '0;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (cnt_reg == '0)
                            st_next = ST_EMPTY;
                        else if (!slot_ok || !valid_reg[slot_idx])
                            st_next = ST_SLOT;
                        else
                        begin
                            valid_next[slot_idx] = 1'b0;
                            cnt_next = cnt_reg - 1'b1;
                            state_next = S_DIV;
                            dreq.start = 1'b1;
                            dreq.divisor = 9'(cnt_next);
                        end
                    end
                    CMD_SETPRIO:
                    begin
                        if (prio_reg >= 6'(PRIORITY_LEVELS))
                            st_next = ST_PRIO;
                        else if (!slot_ok || !valid_reg[slot_idx])
                            st_next = ST_SLOT;
                        else
                        begin
                            wr_en = 1'b1;
                            wr_data = rd_data;
                            wr_data.prio = prio_reg;
                        end
                    end
                    default: st_next = ST_OK;
                endcase
            end
            S_CHARGE:
            begin
                // Operands settle; the product registers this cycle.
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cur_next.vr = cur_reg.vr + {17'd0, prodv};
                state_next = S_WRRUN;
            end
            S_WRRUN:
            begin
                wr_en = 1'b1;
                wr_addr = (cmd_reg == CMD_REMOVE) ? slot_idx : run_reg;
                wr_data = cur_reg;
                if (cmd_reg != CMD_REMOVE)
                begin
                    wr_data.stamp = stc_reg;
                    stc_next = stc_reg + 16'd1;
                end
                scan_next = '0;
                found_next = 1'b0;
                state_next = S_SCAN;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    swi_next = (q < minsw_reg) ? minsw_reg : q;
                    if (cnt_reg == '0)
                        swi_next = '0;
                    state_next = S_FINAL;
                    if (cmd_reg == CMD_REMOVE && run_p_reg && run_reg == slot_idx)
                    begin
                        mula_next = swi_next;
                        mulb_next = weight_of(cur_reg.prio);
                        half_next = 1'b1;
                        if (cnt_reg == '0)
                        begin
                            run_p_next = 1'b0;
                            run_next = '0;
                            state_next = S_CHARGE;
                        end
                        else
                        begin
                            need_pick_next = 1'b1;
                            state_next = S_CHARGE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // One entry read per cycle; evaluate the previous read.
                rd_addr = IW'(scan_reg);
                if (scan_reg != '0 && valid_reg[scan_prev[IW-1:0]])
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (age > oldest_reg)
                            oldest_next = age;
                    end
                    else if (!found_reg || key < bkey_reg ||
                             (key == bkey_reg && age > bage_reg))
                    begin
                        found_next = 1'b1;
                        best_next = scan_prev[IW-1:0];
                        bkey_next = key;
                        bage_next = age;
                        bvr_next = rd_data.vr;
                    end
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == (IW+1)'(MAX_TASKS))
                    state_next = S_SCANEND;
            end
            S_SCANEND:
            begin
                state_next = S_FINAL;
                if (cmd_reg == CMD_ADD)
                begin
                    wr_en = 1'b1;
                    wr_data = cur_reg;
                    if (delta > lim)
                    begin
                        wr_data.vr = minrt_reg;
                        wr_data.stamp = stc_reg - (oldest_reg + 16'd1);
                    end
                    else
                    begin
                        wr_data.stamp = stc_reg;
                        stc_next = stc_reg + 16'd1;
                    end
                    valid_next[slot_idx] = 1'b1;
                    if (!run_p_reg)
                    begin
                        run_next = slot_idx;
                        run_p_next = 1'b1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    dreq.start = 1'b1;
                    dreq.divisor = 9'(cnt_next);
                    state_next = S_DIV;
                end
                else if (found_reg)
                begin
                    run_next = best_reg;
                    run_p_next = 1'b1;
                    minrt_next = bvr_reg;
                end
                else
                    run_p_next = 1'b0;
            end
            S_FINAL:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            run_reg <= '0;
            run_p_reg <= 1'b0;
            cnt_reg <= '0;
            minrt_reg <= '0;
            acc_reg <= '0;
            swi_reg <= '0;
            stc_reg <= '0;
            period_reg <= 32'd20000000;
            minsw_reg <= 32'd1000000;
            done_reg <= 1'b0;
            need_pick_reg <= 1'b0;
            found_reg <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            run_reg <= run_next;
            run_p_reg <= run_p_next;
            cnt_reg <= cnt_next;
            minrt_reg <= minrt_next;
            acc_reg <= acc_next;
            swi_reg <= swi_next;
            stc_reg <= stc_next;
            done_reg <= done_next;
            need_pick_reg <= need_pick_next;
            found_reg <= found_next;
            scan_reg <= scan_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PERIOD)
                    period_reg <= cfg_data;
                else if (cfg_index == REG_MINSW)
                    minsw_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        slot_reg <= slot_next;
        prio_reg <= prio_next;
        fresh_reg <= fresh_next;
        st_reg <= st_next;
        mula_reg <= mula_next;
        mulb_reg <= mulb_next;
        half_reg <= half_next;
        cur_reg <= cur_next;
        best_reg <= best_next;
        bkey_reg <= bkey_next;
        bage_reg <= bage_next;
        bvr_reg <= bvr_next;
        oldest_reg <= oldest_next;
    end

    // After the charge and write-back, removal of the running task picks or ends.
    logic rem_path;
    assign rem_path = (cmd_reg == CMD_REMOVE) && !need_pick_reg;

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done = done_reg;
    assign status = st_reg;
    assign running_valid = run_p_reg && (cnt_reg != '0);
    assign running_slot = running_valid ? 5'(run_reg) : 5'd0;
    assign wait_ns = !running_valid ? 32'hFFFF_FFFF :
                     (acc_reg >= swi_reg) ? 32'd0 : (swi_reg - acc_reg);

    `WFTS_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done, "done held for two cycles")
    `WFTS_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "done during a command")
    `WFTS_ASSERT_IMP(a_run_valid, clk, rst_n, running_valid && !busy,
                     valid_reg[run_reg] || rem_path, "running slot not valid")
endmodule
